// ----- design/cdl_pkg.sv -----
package cdl_pkg;

  localparam int RateW    = 17;
  localparam int RandW    = 16;
  localparam int GenW     = 28;
  localparam int OutCntW  = 5;
  localparam int PaddrW   = 4;
  localparam int PdataW   = 32;
  localparam int NumSpecies = 3;

  localparam logic [RateW-1:0] RATE_RESET = 17'h10000;

  // Register indexes (byte address 4*i)
  localparam logic [1:0] REG_DEATH_A = 2'd0;
  localparam logic [1:0] REG_DEATH_B = 2'd1;
  localparam logic [1:0] REG_DEATH_C = 2'd2;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    SP_A     = 2'd0,
    SP_B     = 2'd1,
    SP_C     = 2'd2,
    SP_EMPTY = 2'd3
  } species_e;

  typedef struct packed {
    func_e                func;
    logic [3:0]           site;
    species_e             species_in;
    logic                 direction;
    logic [RandW-1:0]     rand_fraction;
  } cdl_item_t;

  // Site write request from the rule logic
  typedef struct packed {
    logic     en;
    logic     at_nb;
    species_e code;
  } cdl_wr_t;

  // a eats b, b eats c, c eats a
  function automatic species_e prey_of(input species_e s);
    species_e p;
    case (s)
      SP_A:    p = SP_B;
      SP_B:    p = SP_C;
      SP_C:    p = SP_A;
      default: p = SP_EMPTY;
    endcase
    return p;
  endfunction

  function automatic species_e predator_of(input species_e s);
    species_e p;
    case (s)
      SP_A:    p = SP_C;
      SP_B:    p = SP_A;
      SP_C:    p = SP_B;
      default: p = SP_EMPTY;
    endcase
    return p;
  endfunction

endpackage

// ----- design/cyclic_dominance_lattice_step_core.sv -----
// Rock-paper-scissors ring lattice: one load or interaction step per
// transaction, one result per transaction, in order. The block takes a new
// transaction every cycle while the output side keeps up; the input stalls only
// while the input register holds a transaction and the result register is held.
// A result lands in the output register as its transaction leaves the input
// register: the lattice store reads the two sites into a registered read port
// at the accepting edge, and the rule logic updates counts and lattice as the
// result is registered (a same-edge write is forwarded into the read). Only the
// sites a 4-bit site field can reach are stored; all read as empty after reset
// with no clearing pass. The user must write death rates over the APB port at
// byte addresses 0, 4 and 8 only while the block is idle (not enforced).
module cyclic_dominance_lattice_step_core #(
  parameter int LATTICE_SIZE = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [3:0]                      site_i,
  input  logic [1:0]                      species_in_i,
  input  logic                            direction_i,
  input  logic [cdl_pkg::RandW-1:0]       rand_fraction_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            site_changed_o,
  output logic [cdl_pkg::OutCntW-1:0]     count_a_o,
  output logic [cdl_pkg::OutCntW-1:0]     count_b_o,
  output logic [cdl_pkg::OutCntW-1:0]     count_c_o,
  output logic                            fixated_o,
  output logic [cdl_pkg::GenW-1:0]        generation_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cdl_pkg::PaddrW-1:0]      paddr,
  input  logic [cdl_pkg::PdataW-1:0]      pwdata,
  output logic [cdl_pkg::PdataW-1:0]      prdata,
  output logic                            pready
);

  localparam int AddrW = $clog2(LATTICE_SIZE);
  localparam int CntW  = $clog2(LATTICE_SIZE + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(LATTICE_SIZE - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(LATTICE_SIZE);

  // ---------------- configuration ----------------
  logic [2:0][cdl_pkg::RateW-1:0] rate_q;
  logic                           cfg_wr;
  logic [1:0]                     reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= {3{cdl_pkg::RATE_RESET}};
    end else if (cfg_wr) begin
      case (reg_idx)
        cdl_pkg::REG_DEATH_A: rate_q[0] <= pwdata[cdl_pkg::RateW-1:0];
        cdl_pkg::REG_DEATH_B: rate_q[1] <= pwdata[cdl_pkg::RateW-1:0];
        cdl_pkg::REG_DEATH_C: rate_q[2] <= pwdata[cdl_pkg::RateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cdl_pkg::REG_DEATH_A: prdata = cdl_pkg::PdataW'(rate_q[0]);
      cdl_pkg::REG_DEATH_B: prdata = cdl_pkg::PdataW'(rate_q[1]);
      cdl_pkg::REG_DEATH_C: prdata = cdl_pkg::PdataW'(rate_q[2]);
      default:              prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic s1_vld_q, out_vld_q;
  logic in_acc, out_free, s1_fire;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_fire    = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------- input register ----------------
  cdl_pkg::cdl_item_t s1_item_q;
  logic [AddrW-1:0]   site_l, nb_l, s1_site_q, s1_nb_q;
  logic               in_range, s1_in_range_q;

  assign in_range = 32'(site_i) < LATTICE_SIZE;
  assign site_l   = AddrW'(site_i);

  always_comb begin
    if (direction_i == 1'b0) begin
      nb_l = (site_l == LastAddr) ? '0 : site_l + AddrW'(1);
    end else begin
      nb_l = (site_l == '0) ? LastAddr : site_l - AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q     <= '{func:          cdl_pkg::func_e'(func_i),
                         site:          site_i,
                         species_in:    cdl_pkg::species_e'(species_in_i),
                         direction:     direction_i,
                         rand_fraction: rand_fraction_i};
      s1_site_q     <= site_l;
      s1_nb_q       <= nb_l;
      s1_in_range_q <= in_range;
    end
  end

  // ---------------- lattice store ----------------
  cdl_pkg::species_e site_code, nb_code;
  cdl_pkg::cdl_wr_t  wr;
  logic              st_wr_en;
  logic [AddrW-1:0]  st_wr_addr;

  assign st_wr_en   = s1_fire && wr.en;
  assign st_wr_addr = wr.at_nb ? s1_nb_q : s1_site_q;

  cdl_site_store #(.LATTICE_SIZE(LATTICE_SIZE)) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_en_i        (in_acc),
    .rd_site_addr_i (site_l),
    .rd_nb_addr_i   (nb_l),
    .rd_site_data_o (site_code),
    .rd_nb_data_o   (nb_code),
    .wr_en_i        (st_wr_en),
    .wr_addr_i      (st_wr_addr),
    .wr_data_i      (wr.code)
  );

  // ---------------- rules and counts ----------------
  logic [2:0][CntW-1:0] cnt_q, cnt_d;
  logic                 fix_d;

  cdl_rules #(.LATTICE_SIZE(LATTICE_SIZE)) u_rules (
    .func_i          (s1_item_q.func),
    .in_range_i      (s1_in_range_q),
    .species_in_i    (s1_item_q.species_in),
    .rand_fraction_i (s1_item_q.rand_fraction),
    .site_code_i     (site_code),
    .nb_code_i       (nb_code),
    .cnt_i           (cnt_q),
    .rate_i          (rate_q),
    .wr_o            (wr),
    .cnt_o           (cnt_d)
  );

  assign fix_d = (cnt_d[0] == FullCnt) || (cnt_d[1] == FullCnt) || (cnt_d[2] == FullCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s1_fire) begin
      cnt_q <= cnt_d;
    end
  end

  logic [cdl_pkg::GenW-1:0] gen_next;

  cdl_gen_ctr #(.LATTICE_SIZE(LATTICE_SIZE)) u_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .inc_i      (s1_fire && s1_item_q.func == cdl_pkg::FUNC_STEP),
    .gen_next_o (gen_next)
  );

  // ---------------- result register ----------------
  logic                     res_changed_q, res_fix_q;
  logic [2:0][CntW-1:0]     res_cnt_q;
  logic [cdl_pkg::GenW-1:0] res_gen_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_changed_q <= wr.en;
      res_cnt_q     <= cnt_d;
      res_fix_q     <= fix_d;
      res_gen_q     <= gen_next;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign site_changed_o = res_changed_q;
  assign count_a_o      = cdl_pkg::OutCntW'(res_cnt_q[0]);
  assign count_b_o      = cdl_pkg::OutCntW'(res_cnt_q[1]);
  assign count_c_o      = cdl_pkg::OutCntW'(res_cnt_q[2]);
  assign fixated_o      = res_fix_q;
  assign generation_o   = res_gen_q;

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_vld_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_population_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CntW+2)'(cnt_q[0]) + (CntW+2)'(cnt_q[1]) + (CntW+2)'(cnt_q[2]))
      <= (CntW+2)'(LATTICE_SIZE))
    else $error("species counts exceed lattice size");

  a_fixation_matches_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_fix_q |->
      (res_cnt_q[0] == FullCnt) || (res_cnt_q[1] == FullCnt) || (res_cnt_q[2] == FullCnt))
    else $error("fixation flag without a full species count");

endmodule

// ----- design/cdl_site_store.sv -----
module cdl_site_store #(
  parameter int LATTICE_SIZE = 16,
  localparam int AddrW = $clog2(LATTICE_SIZE)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_site_addr_i,
  input  logic [AddrW-1:0]    rd_nb_addr_i,
  output cdl_pkg::species_e   rd_site_data_o,
  output cdl_pkg::species_e   rd_nb_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  cdl_pkg::species_e   wr_data_i
);

  // Only sites 0..16 and the last site can ever be addressed from a 4-bit site
  // field, so large rings keep just those; the rest stay empty for good.
  localparam int DirectSites = 17;
  localparam int PhysDepth   = (LATTICE_SIZE <= DirectSites + 1) ? LATTICE_SIZE
                                                                  : DirectSites + 1;
  localparam int PhysW       = $clog2(PhysDepth);
  localparam int FarSlot     = DirectSites;

  cdl_pkg::species_e site_mem [PhysDepth];
  logic [PhysDepth-1:0] vld_q;
  cdl_pkg::species_e rd_site_q, rd_nb_q;
  logic [PhysW-1:0] wr_p, rd_site_p, rd_nb_p;

  function automatic logic [PhysW-1:0] phys_idx(input logic [AddrW-1:0] a);
    logic [PhysW-1:0] p;
    if (LATTICE_SIZE <= DirectSites + 1) begin
      p = (32'(a) < LATTICE_SIZE) ? PhysW'(a) : '0;
    end else begin
      p = (32'(a) < DirectSites) ? PhysW'(a) : PhysW'(FarSlot);
    end
    return p;
  endfunction

  assign wr_p      = phys_idx(wr_addr_i);
  assign rd_site_p = phys_idx(rd_site_addr_i);
  assign rd_nb_p   = phys_idx(rd_nb_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_p] <= 1'b1;
    end
  end

  // Forward a write landing on the same edge as the read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      site_mem[wr_p] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && wr_addr_i == rd_site_addr_i) begin
        rd_site_q <= wr_data_i;
      end else begin
        rd_site_q <= vld_q[rd_site_p] ? site_mem[rd_site_p] : cdl_pkg::SP_EMPTY;
      end
      if (wr_en_i && wr_addr_i == rd_nb_addr_i) begin
        rd_nb_q <= wr_data_i;
      end else begin
        rd_nb_q <= vld_q[rd_nb_p] ? site_mem[rd_nb_p] : cdl_pkg::SP_EMPTY;
      end
    end
  end

  assign rd_site_data_o = rd_site_q;
  assign rd_nb_data_o   = rd_nb_q;

endmodule

// ----- design/cdl_rules.sv -----
module cdl_rules #(
  parameter int LATTICE_SIZE = 16,
  localparam int CntW = $clog2(LATTICE_SIZE + 1)
) (
  input  cdl_pkg::func_e                      func_i,
  input  logic                                in_range_i,
  input  cdl_pkg::species_e                   species_in_i,
  input  logic [cdl_pkg::RandW-1:0]           rand_fraction_i,
  input  cdl_pkg::species_e                   site_code_i,
  input  cdl_pkg::species_e                   nb_code_i,
  input  logic [2:0][CntW-1:0]                cnt_i,
  input  logic [2:0][cdl_pkg::RateW-1:0]      rate_i,
  output cdl_pkg::cdl_wr_t                    wr_o,
  output logic [2:0][CntW-1:0]                cnt_o
);

  logic [3:0]                     nz;
  logic [3:0][cdl_pkg::RateW-1:0] rate_x;
  logic [cdl_pkg::RateW-1:0]      rnd_x;
  cdl_pkg::species_e              old_code;
  logic                           dec, inc;

  always_comb begin
    nz     = {1'b0, cnt_i[2] != '0, cnt_i[1] != '0, cnt_i[0] != '0};
    rate_x = {{cdl_pkg::RateW{1'b0}}, rate_i[2], rate_i[1], rate_i[0]};
    rnd_x  = {1'b0, rand_fraction_i};

    wr_o = '{en: 1'b0, at_nb: 1'b0, code: cdl_pkg::SP_EMPTY};
    if (func_i == cdl_pkg::FUNC_LOAD) begin
      if (in_range_i && species_in_i != site_code_i) begin
        wr_o = '{en: 1'b1, at_nb: 1'b0, code: species_in_i};
      end
    end else if (in_range_i && site_code_i != cdl_pkg::SP_EMPTY) begin
      if (nb_code_i == cdl_pkg::prey_of(site_code_i)) begin
        // neighbor is eaten
        if (nz[nb_code_i] && rnd_x <= rate_x[nb_code_i]) begin
          wr_o = '{en: 1'b1, at_nb: 1'b1, code: site_code_i};
        end
      end else if (nb_code_i == cdl_pkg::predator_of(site_code_i)) begin
        // chosen site is eaten
        if (nz[site_code_i] && rnd_x <= rate_x[site_code_i]) begin
          wr_o = '{en: 1'b1, at_nb: 1'b0, code: nb_code_i};
        end
      end
    end

    old_code = wr_o.at_nb ? nb_code_i : site_code_i;
    for (int i = 0; i < cdl_pkg::NumSpecies; i++) begin
      dec = wr_o.en && old_code == cdl_pkg::species_e'(2'(i)) && cnt_i[i] != '0;
      inc = wr_o.en && wr_o.code == cdl_pkg::species_e'(2'(i));
      cnt_o[i] = cnt_i[i] - CntW'(dec) + CntW'(inc);
    end
  end

endmodule

// ----- design/cdl_gen_ctr.sv -----
module cdl_gen_ctr #(
  parameter int LATTICE_SIZE = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        inc_i,
  output logic [cdl_pkg::GenW-1:0]    gen_next_o
);

  localparam int RemW = $clog2(LATTICE_SIZE);
  localparam logic [RemW-1:0] RemLast = RemW'(LATTICE_SIZE - 1);

  logic [31:0]              round_q, round_d;
  logic [RemW-1:0]          rem_q, rem_d;
  logic [cdl_pkg::GenW-1:0] quo_q, quo_d;

  always_comb begin
    round_d = round_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (inc_i) begin
      round_d = round_q + 32'd1;
      if (round_q == '1) begin
        // round counter wraps: quotient restarts from zero
        rem_d = '0;
        quo_d = '0;
      end else if (rem_q == RemLast) begin
        rem_d = '0;
        quo_d = quo_q + 1'b1;
      end else begin
        rem_d = rem_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
    end else begin
      round_q <= round_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
    end
  end

  assign gen_next_o = quo_d;

endmodule
